/* hdl/omnidirectional_point_projection_unit_macros.svh */
// Assertion helpers for the projection unit
`ifndef OMNIDIRECTIONAL_POINT_PROJECTION_UNIT_MACROS_SVH
`define OMNIDIRECTIONAL_POINT_PROJECTION_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define OPPU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("oppu assertion failed");

// next-cycle implication, checked out of reset
`define OPPU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("oppu assertion failed");

`endif

/* hdl/oppu_pkg.sv */
`default_nettype none

package oppu_pkg;

    localparam int MAX_ORDER_DEF   = 16;
    localparam int SQRT_STEPS      = 32;
    localparam int CORDIC_STEPS    = 31;
    localparam int QUOT_W          = 63;
    localparam int CFG_INDEX_W     = 3;
    localparam int S_TDATA_W       = 136;
    localparam int M_TDATA_W       = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AFFINE_C   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AFFINE_D   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AFFINE_E   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POLY_ORDER = 3'd5;

    // word kinds
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_PROJECT = 1'b1;

    // atan(2^-i) in Q2.30
    localparam logic signed [32:0] ATAN_TAB [CORDIC_STEPS] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
        33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
        33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
        33'sd1024,      33'sd512,       33'sd256,       33'sd128,
        33'sd64,        33'sd32,        33'sd16,        33'sd8,
        33'sd4,         33'sd2,         33'sd1
    };

    // control fields that ride along the whole pipe
    typedef struct packed {
        logic               func;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic               behind;
        logic               axis;
    } ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/omnidirectional_point_projection_unit.sv */
// Omnidirectional point projection unit.
// Input stream (s_*): one word per item. s_tuser = func. A write word stores
// a polynomial coefficient and produces no result; a project word carries
// a Q16.16 point and produces exactly one result word on m_*.
// Result stream (m_*): m_tdata = {image_y, image_x}, m_tuser = status
// (1: point not in front of the camera, coordinates zero).
// Configuration: cfg_wr_en / cfg_index / cfg_wdata write one register per
// cycle; write only while the pipe holds no project word.
// Throughput: one word per cycle. From acceptance to m_tvalid a word passes
// the 32-stage square root, 31-stage CORDIC, two stages per polynomial term
// and the 63-stage restoring divider, among other registered stages.
// The whole pipe advances together; while a result waits on m_tready the
// pipe holds and s_tready is low. Nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears the valid bits and the registers
// to their defaults; coefficients must be written before use.
`default_nettype none
`include "omnidirectional_point_projection_unit_macros.svh"

module omnidirectional_point_projection_unit #(
    parameter int MAX_ORDER = oppu_pkg::MAX_ORDER_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // coef_index, coef_value, point_x, point_y, point_z, zero pad
    input  wire  [oppu_pkg::S_TDATA_W-1:0]      s_tdata,
    // func
    input  wire  [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // image_x, image_y
    output logic [oppu_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [0:0]                          m_tuser,
    input  wire                                 cfg_wr_en,
    input  wire  [oppu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [31:0]                         cfg_wdata
);
    import oppu_pkg::*;

    logic               adv;
    logic signed [31:0] center_x_reg, center_y_reg;
    logic signed [31:0] affine_c_reg, affine_d_reg, affine_e_reg;
    logic [4:0]         poly_order_reg;
    logic               out_vld_reg;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic               out_status_reg;

    // whole pipe moves when the output is free
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            affine_c_reg   <= 32'sh10000000;
            affine_d_reg   <= '0;
            affine_e_reg   <= '0;
            poly_order_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER_X:   center_x_reg   <= cfg_wdata;
                REG_CENTER_Y:   center_y_reg   <= cfg_wdata;
                REG_AFFINE_C:   affine_c_reg   <= cfg_wdata;
                REG_AFFINE_D:   affine_d_reg   <= cfg_wdata;
                REG_AFFINE_E:   affine_e_reg   <= cfg_wdata;
                REG_POLY_ORDER: poly_order_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // input register
    logic               s0_vld_reg;
    ctl_t               s0_ctl_reg;
    logic signed [31:0] s0_px_reg, s0_py_reg, s0_pz_reg;
    ctl_t               s0_ctl_next;

    always_comb begin
        s0_ctl_next.func       = s_tuser[0];
        s0_ctl_next.coef_index = s_tdata[3:0];
        s0_ctl_next.coef_value = s_tdata[35:4];
        s0_ctl_next.behind     = !($signed(s_tdata[131:100]) > 32'sd0);
        s0_ctl_next.axis       = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (adv) begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_ctl_reg <= s0_ctl_next;
            s0_px_reg  <= s_tdata[67:36];
            s0_py_reg  <= s_tdata[99:68];
            s0_pz_reg  <= s_tdata[131:100];
        end
    end

    // squares
    logic               s1_vld_reg;
    ctl_t               s1_ctl_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic signed [63:0] s1_pxx_reg, s1_pyy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctl_reg <= s0_ctl_reg;
            s1_px_reg  <= s0_px_reg;
            s1_py_reg  <= s0_py_reg;
            s1_pz_reg  <= s0_pz_reg;
            s1_pxx_reg <= s0_px_reg * s0_px_reg;
            s1_pyy_reg <= s0_py_reg * s0_py_reg;
        end
    end

    // sum of squares
    logic               s2_vld_reg;
    ctl_t               s2_ctl_reg;
    logic signed [31:0] s2_px_reg, s2_py_reg, s2_pz_reg;
    logic [63:0]        s2_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_ctl_reg <= s1_ctl_reg;
            s2_px_reg  <= s1_px_reg;
            s2_py_reg  <= s1_py_reg;
            s2_pz_reg  <= s1_pz_reg;
            s2_sum_reg <= $unsigned(s1_pxx_reg) + $unsigned(s1_pyy_reg);
        end
    end

    // integer square root, one result bit per stage
    logic               sq_vld_reg  [SQRT_STEPS];
    ctl_t               sq_ctl_reg  [SQRT_STEPS];
    logic signed [31:0] sq_px_reg   [SQRT_STEPS];
    logic signed [31:0] sq_py_reg   [SQRT_STEPS];
    logic signed [31:0] sq_pz_reg   [SQRT_STEPS];
    logic [63:0]        sq_rem_reg  [SQRT_STEPS];
    logic [63:0]        sq_root_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic               in_vld;
        ctl_t               in_ctl;
        logic signed [31:0] in_px, in_py, in_pz;
        logic [63:0]        in_rem, in_root, trial;

        if (k == 0) begin : g_first
            assign in_vld  = s2_vld_reg;
            assign in_ctl  = s2_ctl_reg;
            assign in_px   = s2_px_reg;
            assign in_py   = s2_py_reg;
            assign in_pz   = s2_pz_reg;
            assign in_rem  = s2_sum_reg;
            assign in_root = '0;
        end else begin : g_rest
            assign in_vld  = sq_vld_reg[k-1];
            assign in_ctl  = sq_ctl_reg[k-1];
            assign in_px   = sq_px_reg[k-1];
            assign in_py   = sq_py_reg[k-1];
            assign in_pz   = sq_pz_reg[k-1];
            assign in_rem  = sq_rem_reg[k-1];
            assign in_root = sq_root_reg[k-1];
        end

        assign trial = in_root + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[k] <= in_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_ctl_reg[k] <= in_ctl;
                sq_px_reg[k]  <= in_px;
                sq_py_reg[k]  <= in_py;
                sq_pz_reg[k]  <= in_pz;
                if (in_rem >= trial) begin
                    sq_rem_reg[k]  <= in_rem - trial;
                    sq_root_reg[k] <= (in_root >> 1) + BIT;
                end else begin
                    sq_rem_reg[k]  <= in_rem;
                    sq_root_reg[k] <= in_root >> 1;
                end
            end
        end
    end

    // CORDIC vectoring for atan(pz / norm)
    logic               co_vld_reg [CORDIC_STEPS];
    ctl_t               co_ctl_reg [CORDIC_STEPS];
    logic signed [31:0] co_px_reg  [CORDIC_STEPS];
    logic signed [31:0] co_py_reg  [CORDIC_STEPS];
    logic [31:0]        co_nrm_reg [CORDIC_STEPS];
    logic signed [63:0] co_x_reg   [CORDIC_STEPS];
    logic signed [63:0] co_y_reg   [CORDIC_STEPS];
    logic signed [32:0] co_z_reg   [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic               in_vld;
        ctl_t               in_ctl;
        logic signed [31:0] in_px, in_py;
        logic [31:0]        in_nrm;
        logic signed [63:0] in_x, in_y, dx, dy;
        logic signed [32:0] in_z;

        if (i == 0) begin : g_first
            logic [31:0]        nrm;
            logic signed [31:0] pz;
            assign nrm    = sq_root_reg[SQRT_STEPS-1][31:0];
            assign pz     = sq_pz_reg[SQRT_STEPS-1];
            assign in_vld = sq_vld_reg[SQRT_STEPS-1];
            always_comb begin
                in_ctl      = sq_ctl_reg[SQRT_STEPS-1];
                in_ctl.axis = (nrm == 32'd0);
            end
            assign in_px  = sq_px_reg[SQRT_STEPS-1];
            assign in_py  = sq_py_reg[SQRT_STEPS-1];
            assign in_nrm = nrm;
            assign in_x   = $signed({4'b0, nrm, 28'b0});
            assign in_y   = $signed({{4{pz[31]}}, pz, 28'b0});
            assign in_z   = '0;
        end else begin : g_rest
            assign in_vld = co_vld_reg[i-1];
            assign in_ctl = co_ctl_reg[i-1];
            assign in_px  = co_px_reg[i-1];
            assign in_py  = co_py_reg[i-1];
            assign in_nrm = co_nrm_reg[i-1];
            assign in_x   = co_x_reg[i-1];
            assign in_y   = co_y_reg[i-1];
            assign in_z   = co_z_reg[i-1];
        end

        assign dx = in_y >>> i;
        assign dy = in_x >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                co_vld_reg[i] <= 1'b0;
            end else if (adv) begin
                co_vld_reg[i] <= in_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                co_ctl_reg[i] <= in_ctl;
                co_px_reg[i]  <= in_px;
                co_py_reg[i]  <= in_py;
                co_nrm_reg[i] <= in_nrm;
                if (!in_y[63]) begin
                    co_x_reg[i] <= in_x + dx;
                    co_y_reg[i] <= in_y - dy;
                    co_z_reg[i] <= in_z + ATAN_TAB[i];
                end else begin
                    co_x_reg[i] <= in_x - dx;
                    co_y_reg[i] <= in_y + dy;
                    co_z_reg[i] <= in_z - ATAN_TAB[i];
                end
            end
        end
    end

    // theta = -z
    logic               th_vld_reg;
    ctl_t               th_ctl_reg;
    logic signed [31:0] th_px_reg, th_py_reg;
    logic [31:0]        th_nrm_reg;
    logic signed [32:0] th_theta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_vld_reg <= 1'b0;
        end else if (adv) begin
            th_vld_reg <= co_vld_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            th_ctl_reg   <= co_ctl_reg[CORDIC_STEPS-1];
            th_px_reg    <= co_px_reg[CORDIC_STEPS-1];
            th_py_reg    <= co_py_reg[CORDIC_STEPS-1];
            th_nrm_reg   <= co_nrm_reg[CORDIC_STEPS-1];
            th_theta_reg <= -co_z_reg[CORDIC_STEPS-1];
        end
    end

    // Horner polynomial: a multiply stage and an add stage per term.
    // Term j uses slot MAX_ORDER-1-j; slots at or above the order give 0.
    // A coefficient word updates its slot as it passes that slot's adder,
    // so it is ordered exactly against the points around it.
    logic               hm_vld_reg   [MAX_ORDER];
    ctl_t               hm_ctl_reg   [MAX_ORDER];
    logic signed [31:0] hm_px_reg    [MAX_ORDER];
    logic signed [31:0] hm_py_reg    [MAX_ORDER];
    logic [31:0]        hm_nrm_reg   [MAX_ORDER];
    logic signed [32:0] hm_theta_reg [MAX_ORDER];
    logic signed [64:0] hm_prod_reg  [MAX_ORDER];

    logic               ha_vld_reg   [MAX_ORDER];
    ctl_t               ha_ctl_reg   [MAX_ORDER];
    logic signed [31:0] ha_px_reg    [MAX_ORDER];
    logic signed [31:0] ha_py_reg    [MAX_ORDER];
    logic [31:0]        ha_nrm_reg   [MAX_ORDER];
    logic signed [32:0] ha_theta_reg [MAX_ORDER];
    logic signed [31:0] ha_acc_reg   [MAX_ORDER];

    for (genvar j = 0; j < MAX_ORDER; j++) begin : g_horner
        localparam int SLOT = MAX_ORDER - 1 - j;
        logic               in_vld;
        ctl_t               in_ctl;
        logic signed [31:0] in_px, in_py, in_acc;
        logic [31:0]        in_nrm;
        logic signed [32:0] in_theta;
        logic signed [31:0] coef_reg;
        logic signed [35:0] prod_sh, sum_next;
        logic signed [31:0] acc_next;
        logic               active;

        if (j == 0) begin : g_first
            assign in_vld   = th_vld_reg;
            assign in_ctl   = th_ctl_reg;
            assign in_px    = th_px_reg;
            assign in_py    = th_py_reg;
            assign in_nrm   = th_nrm_reg;
            assign in_theta = th_theta_reg;
            assign in_acc   = '0;
        end else begin : g_rest
            assign in_vld   = ha_vld_reg[j-1];
            assign in_ctl   = ha_ctl_reg[j-1];
            assign in_px    = ha_px_reg[j-1];
            assign in_py    = ha_py_reg[j-1];
            assign in_nrm   = ha_nrm_reg[j-1];
            assign in_theta = ha_theta_reg[j-1];
            assign in_acc   = ha_acc_reg[j-1];
        end

        // multiply
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hm_vld_reg[j] <= 1'b0;
            end else if (adv) begin
                hm_vld_reg[j] <= in_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                hm_ctl_reg[j]   <= in_ctl;
                hm_px_reg[j]    <= in_px;
                hm_py_reg[j]    <= in_py;
                hm_nrm_reg[j]   <= in_nrm;
                hm_theta_reg[j] <= in_theta;
                hm_prod_reg[j]  <= in_acc * in_theta;
            end
        end

        // coefficient slot
        always_ff @(posedge aclk) begin
            if (adv && hm_vld_reg[j] && hm_ctl_reg[j].func == FUNC_WRITE &&
                int'(hm_ctl_reg[j].coef_index) == SLOT) begin
                coef_reg <= hm_ctl_reg[j].coef_value;
            end
        end

        // add and saturate
        assign active   = {1'b0, poly_order_reg} > 6'(SLOT);
        assign prod_sh  = 36'(hm_prod_reg[j] >>> 30);
        assign sum_next = prod_sh + 36'(coef_reg);
        assign acc_next = active ? sat32(64'(sum_next)) : 32'sd0;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ha_vld_reg[j] <= 1'b0;
            end else if (adv) begin
                ha_vld_reg[j] <= hm_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ha_ctl_reg[j]   <= hm_ctl_reg[j];
                ha_px_reg[j]    <= hm_px_reg[j];
                ha_py_reg[j]    <= hm_py_reg[j];
                ha_nrm_reg[j]   <= hm_nrm_reg[j];
                ha_theta_reg[j] <= hm_theta_reg[j];
                ha_acc_reg[j]   <= acc_next;
            end
        end
    end

    // py*rho and px*rho
    logic               pr_vld_reg;
    ctl_t               pr_ctl_reg;
    logic [31:0]        pr_nrm_reg;
    logic signed [63:0] pr_up_reg, pr_vp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_vld_reg <= 1'b0;
        end else if (adv) begin
            pr_vld_reg <= ha_vld_reg[MAX_ORDER-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_ctl_reg <= ha_ctl_reg[MAX_ORDER-1];
            pr_nrm_reg <= ha_nrm_reg[MAX_ORDER-1];
            pr_up_reg  <= ha_py_reg[MAX_ORDER-1] * ha_acc_reg[MAX_ORDER-1];
            pr_vp_reg  <= ha_px_reg[MAX_ORDER-1] * ha_acc_reg[MAX_ORDER-1];
        end
    end

    // magnitudes for the divider
    logic               ab_vld_reg;
    ctl_t               ab_ctl_reg;
    logic [31:0]        ab_nrm_reg;
    logic [QUOT_W-1:0]  ab_um_reg, ab_vm_reg;
    logic               ab_un_reg, ab_vn_reg;
    logic signed [63:0] up_neg, vp_neg;

    assign up_neg = -pr_up_reg;
    assign vp_neg = -pr_vp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ab_vld_reg <= 1'b0;
        end else if (adv) begin
            ab_vld_reg <= pr_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ab_ctl_reg <= pr_ctl_reg;
            ab_nrm_reg <= pr_nrm_reg;
            ab_un_reg  <= pr_up_reg[63];
            ab_vn_reg  <= pr_vp_reg[63];
            ab_um_reg  <= pr_up_reg[63] ? up_neg[QUOT_W-1:0] : pr_up_reg[QUOT_W-1:0];
            ab_vm_reg  <= pr_vp_reg[63] ? vp_neg[QUOT_W-1:0] : pr_vp_reg[QUOT_W-1:0];
        end
    end

    // restoring divide by norm, one quotient bit per stage for u and v
    logic               dv_vld_reg  [QUOT_W];
    ctl_t               dv_ctl_reg  [QUOT_W];
    logic [31:0]        dv_nrm_reg  [QUOT_W];
    logic               dv_un_reg   [QUOT_W];
    logic               dv_vn_reg   [QUOT_W];
    logic [31:0]        dv_ur_reg   [QUOT_W];
    logic [31:0]        dv_vr_reg   [QUOT_W];
    logic [QUOT_W-1:0]  dv_uq_reg   [QUOT_W];
    logic [QUOT_W-1:0]  dv_vq_reg   [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_div
        logic              in_vld, in_un, in_vn;
        ctl_t              in_ctl;
        logic [31:0]       in_nrm, in_ur, in_vr;
        logic [QUOT_W-1:0] in_uq, in_vq;
        logic [32:0]       u_sh, v_sh, u_diff, v_diff;
        logic              u_take, v_take;

        if (k == 0) begin : g_first
            assign in_vld = ab_vld_reg;
            assign in_ctl = ab_ctl_reg;
            assign in_nrm = ab_nrm_reg;
            assign in_un  = ab_un_reg;
            assign in_vn  = ab_vn_reg;
            assign in_ur  = '0;
            assign in_vr  = '0;
            assign in_uq  = ab_um_reg;
            assign in_vq  = ab_vm_reg;
        end else begin : g_rest
            assign in_vld = dv_vld_reg[k-1];
            assign in_ctl = dv_ctl_reg[k-1];
            assign in_nrm = dv_nrm_reg[k-1];
            assign in_un  = dv_un_reg[k-1];
            assign in_vn  = dv_vn_reg[k-1];
            assign in_ur  = dv_ur_reg[k-1];
            assign in_vr  = dv_vr_reg[k-1];
            assign in_uq  = dv_uq_reg[k-1];
            assign in_vq  = dv_vq_reg[k-1];
        end

        assign u_sh   = {in_ur, in_uq[QUOT_W-1]};
        assign v_sh   = {in_vr, in_vq[QUOT_W-1]};
        assign u_take = u_sh >= {1'b0, in_nrm};
        assign v_take = v_sh >= {1'b0, in_nrm};
        assign u_diff = u_sh - {1'b0, in_nrm};
        assign v_diff = v_sh - {1'b0, in_nrm};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[k] <= in_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_ctl_reg[k] <= in_ctl;
                dv_nrm_reg[k] <= in_nrm;
                dv_un_reg[k]  <= in_un;
                dv_vn_reg[k]  <= in_vn;
                dv_ur_reg[k]  <= u_take ? u_diff[31:0] : u_sh[31:0];
                dv_vr_reg[k]  <= v_take ? v_diff[31:0] : v_sh[31:0];
                dv_uq_reg[k]  <= {in_uq[QUOT_W-2:0], u_take};
                dv_vq_reg[k]  <= {in_vq[QUOT_W-2:0], v_take};
            end
        end
    end

    // restore signs, truncation toward zero
    logic               sg_vld_reg;
    ctl_t               sg_ctl_reg;
    logic signed [63:0] sg_u_reg, sg_v_reg;
    logic signed [63:0] u_mag, v_mag;

    assign u_mag = $signed({1'b0, dv_uq_reg[QUOT_W-1]});
    assign v_mag = $signed({1'b0, dv_vq_reg[QUOT_W-1]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sg_vld_reg <= 1'b0;
        end else if (adv) begin
            sg_vld_reg <= dv_vld_reg[QUOT_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sg_ctl_reg <= dv_ctl_reg[QUOT_W-1];
            sg_u_reg   <= dv_un_reg[QUOT_W-1] ? -u_mag : u_mag;
            sg_v_reg   <= dv_vn_reg[QUOT_W-1] ? -v_mag : v_mag;
        end
    end

    // affine partial products: low products kept modulo 2^64, high ones modulo 2^32
    logic               pp_vld_reg;
    ctl_t               pp_ctl_reg;
    logic signed [63:0] pp_v_reg;
    logic [63:0]        pp_cu_lo_reg, pp_dv_lo_reg, pp_eu_lo_reg;
    logic [31:0]        pp_cu_hi_reg, pp_dv_hi_reg, pp_eu_hi_reg;
    logic signed [64:0] cu_lo, dv_lo, eu_lo;
    logic signed [63:0] cu_hi, dv_hi, eu_hi;

    assign cu_lo = affine_c_reg * $signed({1'b0, sg_u_reg[31:0]});
    assign dv_lo = affine_d_reg * $signed({1'b0, sg_v_reg[31:0]});
    assign eu_lo = affine_e_reg * $signed({1'b0, sg_u_reg[31:0]});
    assign cu_hi = affine_c_reg * $signed(sg_u_reg[63:32]);
    assign dv_hi = affine_d_reg * $signed(sg_v_reg[63:32]);
    assign eu_hi = affine_e_reg * $signed(sg_u_reg[63:32]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_vld_reg <= 1'b0;
        end else if (adv) begin
            pp_vld_reg <= sg_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pp_ctl_reg   <= sg_ctl_reg;
            pp_v_reg     <= sg_v_reg;
            pp_cu_lo_reg <= cu_lo[63:0];
            pp_dv_lo_reg <= dv_lo[63:0];
            pp_eu_lo_reg <= eu_lo[63:0];
            pp_cu_hi_reg <= cu_hi[31:0];
            pp_dv_hi_reg <= dv_hi[31:0];
            pp_eu_hi_reg <= eu_hi[31:0];
        end
    end

    // combine partials
    logic               cb_vld_reg;
    ctl_t               cb_ctl_reg;
    logic signed [63:0] cb_v_reg, cb_cu_reg, cb_dv_reg, cb_eu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cb_vld_reg <= 1'b0;
        end else if (adv) begin
            cb_vld_reg <= pp_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cb_ctl_reg <= pp_ctl_reg;
            cb_v_reg   <= pp_v_reg;
            cb_cu_reg  <= $signed(pp_cu_lo_reg + {pp_cu_hi_reg, 32'b0});
            cb_dv_reg  <= $signed(pp_dv_lo_reg + {pp_dv_hi_reg, 32'b0});
            cb_eu_reg  <= $signed(pp_eu_lo_reg + {pp_eu_hi_reg, 32'b0});
        end
    end

    // final sums, special cases, output register
    logic signed [63:0] y_sum, x_sum;
    logic signed [31:0] x_next, y_next;

    assign y_sum = (cb_cu_reg >>> 28) + (cb_dv_reg >>> 28) + 64'(center_y_reg);
    assign x_sum = (cb_eu_reg >>> 28) + cb_v_reg + 64'(center_x_reg);

    always_comb begin
        if (cb_ctl_reg.behind) begin
            x_next = '0;
            y_next = '0;
        end else if (cb_ctl_reg.axis) begin
            x_next = center_x_reg;
            y_next = center_y_reg;
        end else begin
            x_next = sat32(x_sum);
            y_next = sat32(y_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= cb_vld_reg && (cb_ctl_reg.func == FUNC_PROJECT);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_x_reg      <= x_next;
            out_y_reg      <= y_next;
            out_status_reg <= cb_ctl_reg.behind;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = {out_y_reg, out_x_reg};
    assign m_tuser[0] = out_status_reg;

    // a waiting result holds the whole pipe
    `OPPU_ASSERT_IMP(a_stall_holds_input, m_tvalid && !m_tready, !s_tready)
    // a point behind the camera reports zero coordinates
    `OPPU_ASSERT_IMP(a_behind_zero, m_tvalid && m_tuser[0], m_tdata == '0)
    // a stalled pipe keeps the root stage steady
    `OPPU_ASSERT_NXT(a_stall_freezes_pipe, !adv,
                     $stable(out_x_reg) && $stable(sq_root_reg[SQRT_STEPS-1]))

endmodule

`default_nettype wire
